// ===== design/e80dc_pkg.sv =====
// ----------------------------------------------------------------------------
// e80dc_pkg
// Shared types and constants for the extended/double converter.
// ----------------------------------------------------------------------------
package e80dc_pkg;

  localparam logic [14:0] ExtExpMax  = 15'h7fff;
  localparam logic [10:0] DblExpMax  = 11'h7ff;
  localparam int          ExtBias    = 16383;
  localparam int          DblBias    = 1023;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_DOWN    = 2'd1,
    RM_UP      = 2'd2,
    RM_ZERO    = 2'd3
  } round_mode_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_STORE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] ext_significand;
    logic [15:0] ext_sign_exponent;
    logic [63:0] double_in;
  } operand_t;

  typedef struct packed {
    logic [63:0] double_out;
    logic [63:0] ext_significand_out;
    logic [15:0] ext_sign_exponent_out;
  } result_t;

endpackage

// ===== design/ext80_double_converter_unit.sv =====
// ----------------------------------------------------------------------------
// ext80_double_converter_unit
// x87 extended <-> IEEE double converter.
// ----------------------------------------------------------------------------
// One operand is taken per cycle while in_stall is low; each result passes
// through the op register and then the output register, and a new operand
// is taken while the result waits as long as the output stage frees in the
// same cycle. The whole conversion is one combinational pass between the
// input register and the result register, bounded by the 64-bit leading-one
// search, normalize shift and 53-bit rounding increment. The user must write
// rounding_mode over the cfg port only while idle; the unit does not check.
module ext80_double_converter_unit import e80dc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [63:0] ext_significand,
  input  logic [15:0] ext_sign_exponent,
  input  logic [63:0] double_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] double_out,
  output logic [63:0] ext_significand_out,
  output logic [15:0] ext_sign_exponent_out
);

  round_mode_t rounding_mode;
  operand_t    op;
  logic        op_valid;
  result_t     res;
  result_t     res_next;
  logic        res_valid;
  logic [63:0] load_dbl;
  logic [63:0] store_sig;
  logic [15:0] store_se;
  logic        adv;

  assign cfg_ready = 1'b1;
  // the op stage moves when the result register is empty or drains
  assign adv      = !res_valid || !out_stall;
  assign in_stall = op_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode <= RM_NEAREST;
    end else if (cfg_valid && cfg_ready) begin
      rounding_mode <= round_mode_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= op_valid;
      end
      if (!in_stall) begin
        op_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op <= '{cmd: cmd_t'(cmd), ext_significand: ext_significand,
              ext_sign_exponent: ext_sign_exponent, double_in: double_in};
    end
    if (adv && op_valid) begin
      res <= res_next;
    end
  end

  e80dc_load u_load (
    .sig   (op.ext_significand),
    .se    (op.ext_sign_exponent),
    .rmode (rounding_mode),
    .dbl   (load_dbl)
  );

  e80dc_store u_store (
    .dbl (op.double_in),
    .sig (store_sig),
    .se  (store_se)
  );

  always_comb begin
    if (op.cmd == CMD_LOAD) begin
      res_next = '{double_out: load_dbl, ext_significand_out: 64'd0,
                   ext_sign_exponent_out: 16'd0};
    end else begin
      res_next = '{double_out: 64'd0, ext_significand_out: store_sig,
                   ext_sign_exponent_out: store_se};
    end
  end

  assign out_valid             = res_valid;
  assign double_out            = res.double_out;
  assign ext_significand_out   = res.ext_significand_out;
  assign ext_sign_exponent_out = res.ext_sign_exponent_out;

endmodule

// ===== design/e80dc_load.sv =====
// ----------------------------------------------------------------------------
// e80dc_load
// Extended to double: normalize, round to 53 bits, rebias.
// ----------------------------------------------------------------------------
module e80dc_load import e80dc_pkg::*; (
  input  logic [63:0] sig,
  input  logic [15:0] se,
  input  round_mode_t rmode,
  output logic [63:0] dbl
);

  logic        sign;
  logic [14:0] exp;
  logic [5:0]  p;
  logic [63:0] norm;
  logic [52:0] mant;
  logic [10:0] rem;
  logic        inc;
  logic [53:0] mant_r;
  logic [52:0] mant_f;
  logic [6:0]  p_f;
  logic signed [17:0] e;

  always_comb begin
    sign = se[15];
    exp  = se[14:0];
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (sig[i]) p = 6'(i);
    end
    norm = sig << (6'd63 - p);
    // with p <= 52 the low bits are zero after the shift, so no rounding
    mant = norm[63:11];
    rem  = norm[10:0];
    case (rmode)
      RM_NEAREST: inc = rem[10] && ((rem[9:0] != 10'd0) || mant[0]);
      RM_DOWN:    inc = sign && (rem != 11'd0);
      RM_UP:      inc = !sign && (rem != 11'd0);
      default:    inc = 1'b0;
    endcase
    mant_r = {1'b0, mant} + 54'(inc);
    if (mant_r[53]) begin
      mant_f = mant_r[53:1];
      p_f    = 7'(p) + 7'd1;
    end else begin
      mant_f = mant_r[52:0];
      p_f    = 7'(p);
    end
    e = 18'(DblBias) + 18'(p_f) + 18'(exp) - 18'(ExtBias) - 18'sd63;

    if (exp == ExtExpMax) begin
      dbl = {sign, DblExpMax, (sig[62:0] != 63'd0), 51'd0};
    end else if (sig == 64'd0 || e <= 18'sd0) begin
      dbl = {sign, 63'd0};
    end else if (e >= 18'sd2047) begin
      dbl = {sign, DblExpMax, 52'd0};
    end else begin
      dbl = {sign, e[10:0], mant_f[51:0]};
    end
  end

endmodule

// ===== design/e80dc_store.sv =====
// ----------------------------------------------------------------------------
// e80dc_store
// Double to extended: flush denormals, widen fraction, rebias.
// ----------------------------------------------------------------------------
module e80dc_store import e80dc_pkg::*; (
  input  logic [63:0] dbl,
  output logic [63:0] sig,
  output logic [15:0] se
);

  logic [10:0] exp;

  always_comb begin
    exp = dbl[62:52];
    if (exp == 11'd0) begin
      sig = 64'd0;
      se  = {dbl[63], 15'd0};
    end else if (exp == DblExpMax) begin
      sig = {1'b1, dbl[51:0], 11'd0};
      se  = {dbl[63], ExtExpMax};
    end else begin
      sig = {1'b1, dbl[51:0], 11'd0};
      se  = {dbl[63], 15'(15'(exp) + 15'(ExtBias - DblBias))};
    end
  end

endmodule

// ===== sim/ext80_double_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ext80_double_converter_checker
// Watches the operand, result and config channels of the converter, predicts
// each result from the accepted operand and the current rounding mode, and
// compares field by field in order.
// ----------------------------------------------------------------------------
module ext80_double_converter_checker import e80dc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [63:0] ext_significand,
  input  logic [15:0] ext_sign_exponent,
  input  logic [63:0] double_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] double_out,
  input  logic [63:0] ext_significand_out,
  input  logic [15:0] ext_sign_exponent_out,
  output int          fail_count,
  output int          pending_count
);

  round_mode_t rmode;
  result_t     expected_q[$];

  function automatic logic [63:0] load_to_double(logic [63:0] sig, logic [15:0] se,
                                                 round_mode_t rm);
    logic [63:0] sgn;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    int          exp;
    int          p;
    int          sh;
    int          e;
    logic        inc;
    sgn = {se[15], 63'd0};
    exp = se[14:0];
    if (se[14:0] == ExtExpMax)
      return sgn | {1'b0, DblExpMax, 52'd0} | ((sig[62:0] != 0) ? (64'd1 << 51) : 64'd0);
    if (sig == 0)
      return sgn;
    p = 0;
    for (int i = 0; i < 64; i++)
      if (sig[i]) p = i;
    if (p <= 52) begin
      mant = sig << (52 - p);
    end else begin
      sh   = p - 52;
      rem  = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      mant = sig >> sh;
      case (rm)
        RM_NEAREST: inc = (rem > half) || (rem == half && mant[0]);
        RM_DOWN:    inc = se[15] && rem != 0;
        RM_UP:      inc = !se[15] && rem != 0;
        default:    inc = 1'b0;
      endcase
      if (inc) begin
        mant = mant + 1;
        if (mant == (64'd1 << 53)) begin
          mant = mant >> 1;
          p++;
        end
      end
    end
    e = DblBias + p + exp - ExtBias - 63;
    if (e <= 0) return sgn;
    if (e >= 2047) return sgn | {1'b0, DblExpMax, 52'd0};
    return sgn | (64'(e) << 52) | (mant & ((64'd1 << 52) - 1));
  endfunction

  function automatic result_t convert(logic c, logic [63:0] sig, logic [15:0] se,
                                      logic [63:0] dbl, round_mode_t rm);
    result_t r;
    logic [10:0] dexp;
    r = '0;
    dexp = dbl[62:52];
    if (cmd_t'(c) == CMD_LOAD) begin
      r.double_out = load_to_double(sig, se, rm);
    end else if (dexp == 0) begin
      r.ext_sign_exponent_out = {dbl[63], 15'd0};
    end else begin
      r.ext_significand_out = {1'b1, dbl[51:0], 11'd0};
      if (dexp == DblExpMax)
        r.ext_sign_exponent_out = {dbl[63], ExtExpMax};
      else
        r.ext_sign_exponent_out = {dbl[63], 15'(int'(dexp) - DblBias + ExtBias)};
    end
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rmode      <= RM_NEAREST;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer dbl=%h sig=%h se=%h", $time,
                   double_out, ext_significand_out, ext_sign_exponent_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.double_out !== double_out ||
              want.ext_significand_out !== ext_significand_out ||
              want.ext_sign_exponent_out !== ext_sign_exponent_out) begin
            $display("%0t: mismatch expected dbl=%h sig=%h se=%h got dbl=%h sig=%h se=%h",
                     $time, want.double_out, want.ext_significand_out,
                     want.ext_sign_exponent_out, double_out, ext_significand_out,
                     ext_sign_exponent_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(convert(cmd, ext_significand, ext_sign_exponent, double_in,
                                     rmode));
      if (cfg_valid && cfg_ready)
        rmode <= round_mode_t'(cfg_data);
    end
  end

endmodule

// ===== sim/ext80_double_converter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ext80_double_converter_unit_test
// Drives directed and random operands through the converter under all four
// rounding modes with random idling on both sides; the checker predicts.
// ----------------------------------------------------------------------------
module ext80_double_converter_unit_test;
  import e80dc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [63:0] ext_significand = '0;
  logic [15:0] ext_sign_exponent = '0;
  logic [63:0] double_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] double_out;
  logic [63:0] ext_significand_out;
  logic [15:0] ext_sign_exponent_out;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          quiet_tail = 1'b0;
  bit          long_hold = 1'b0;

  always #5 clk = ~clk;

  ext80_double_converter_unit dut (.*);
  ext80_double_converter_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_op(logic c, logic [63:0] sig, logic [15:0] se, logic [63:0] dbl);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    cmd               <= c;
    ext_significand   <= sig;
    ext_sign_exponent <= se;
    double_in         <= dbl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rounding(round_mode_t rm);
    cfg_valid <= 1'b1;
    cfg_data  <= rm;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_op;
    logic [63:0] sig;
    logic [15:0] se;
    logic [63:0] dbl;
    sig = rand64();
    se  = 16'($urandom());
    dbl = rand64();
    case ($urandom_range(0, 9))
      0: se[14:0] = ExtExpMax;
      1: se[14:0] = 15'($urandom_range(0, 40));
      2: se[14:0] = 15'(ExtBias - DblBias - 60 + $urandom_range(0, 120));
      3: se[14:0] = 15'(ExtBias + DblBias - 20 + $urandom_range(0, 40));
      4: se[14:0] = 15'(ExtBias - 64 + $urandom_range(0, 128));
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: sig = sig >> $urandom_range(1, 63);
      1: sig[10:0] = {1'b1, 10'd0};
      2: sig = 64'hFFFF_FFFF_FFFF_F800 | sig[10:0];
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: dbl[62:52] = 11'd0;
      1: dbl[62:52] = DblExpMax;
      default: ;
    endcase
    send_op(1'($urandom_range(0, 1)), sig, se, dbl);
  endtask

  initial begin
    logic [15:0] bias_se;
    bias_se = 16'(ExtBias);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, specials, rounding ties
    send_op(CMD_LOAD, 64'h0, 16'h8000, 64'h0);
    send_op(CMD_LOAD, 64'h0, 16'h3fff, 64'h0);
    send_op(CMD_LOAD, 64'h8000_0000_0000_0000, 16'h7fff, 64'h0);
    send_op(CMD_LOAD, 64'h0000_0000_0000_0001, 16'hffff, 64'h0);
    send_op(CMD_LOAD, 64'h4000_0000_0000_0000, 16'h7fff, 64'h0);
    send_op(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7ffe, 64'h0);
    send_op(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hffff, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(CMD_LOAD, 64'h0000_0000_0000_0001, 16'h0000, 64'h0);
    send_op(CMD_LOAD, 64'h8000_0000_0000_0400, bias_se, 64'h0);
    send_op(CMD_LOAD, 64'h8000_0000_0000_0C00, bias_se | 16'h8000, 64'h0);
    send_op(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FC00, bias_se, 64'h0);
    send_op(CMD_LOAD, 64'h8000_0000_0000_0000, 16'(ExtBias - DblBias + 1), 64'h0);
    send_op(CMD_LOAD, 64'h8000_0000_0000_0000, 16'(ExtBias - DblBias), 64'h0);
    send_op(CMD_LOAD, 64'h0000_0000_0000_0001, 16'(ExtBias), 64'h0);
    send_op(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hffff, 64'h0);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'h8000_0000_0000_0000);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'h800F_FFFF_FFFF_FFFF);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'h7FF0_0000_0000_0000);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'h3FF0_0000_0000_0000);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'h0010_0000_0000_0001);
    send_op(CMD_STORE, 64'h0, 16'h0, 64'hFFEF_FFFF_FFFF_FFFF);
    drain();

    // random under each rounding mode, extremes first
    for (int m = 0; m < 4; m++) begin
      set_rounding(round_mode_t'(m == 0 ? 3 : m == 1 ? 0 : m == 2 ? 1 : 2));
      if (m == 1) begin
        long_hold = 1'b1;
        repeat (100) random_op();
      end
      repeat (300) random_op();
      drain();
    end
    quiet_tail = 1'b1;
    repeat (100) random_op();
    drain();
    repeat (20) @(posedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
